/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true out of reset
`define MBD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

/* hw/rtl/mbd_pkg.sv */
package mbd_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 10;
  localparam int COORD_W     = 11;
  localparam int ROW_W       = 12;
  localparam int MAX_SRC_HEIGHT = 4096;
  localparam int RESET_SIZE  = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_PIX_W   = 32;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

  // what the back end does with one queued word
  typedef struct packed {
    logic emit;       // odd row: produce an output pixel, else store the pair sum
    logic copy;       // last output row, if not also the first: repeat the stored first row
    logic first_col;
    logic last_col;
    logic first_row;
    logic done;
  } op_ctl_t;

endpackage

/* hw/rtl/mip_box_downsample_seam.sv */
// out_tvalid rises once a block's last pixel has passed the queue, result stage and output register
// throughput: one source pixel per cycle; a 4-deep queue absorbs output stalls and
// in_tready drops only once that queue is full
// reset (rst_n, synchronous): position and pipeline cleared, sizes back to 256x256;
// line buffers are not cleared. any size write restarts the level
module mip_box_downsample_seam #(
  parameter int MAX_SRC_WIDTH = 4096,
  parameter int CHANNELS      = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // chan0_in, chan1_in, chan2_in, chan3_in
  input  logic [mbd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // chan0_out, chan1_out, chan2_out, chan3_out, out_col, out_row, zero fill
  output logic [mbd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  localparam int LINE_DEPTH = MAX_SRC_WIDTH / 2;
  localparam int LW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PAIR_W     = CHANNELS * mbd_pkg::SUM_W;
  localparam int CTL_W      = $bits(mbd_pkg::op_ctl_t);
  localparam int QW         = CTL_W + LW + mbd_pkg::COORD_W + PAIR_W;

  logic                        push, q_pop, q_full, q_empty, restart;
  mbd_pkg::op_ctl_t            f_ctl, q_ctl;
  logic [LW-1:0]               f_ox, q_ox;
  logic [mbd_pkg::COORD_W-1:0] f_oy, q_oy;
  logic [PAIR_W-1:0]           f_pair, q_pair;
  logic [QW-1:0]               q_rdata;

  mbd_front #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .CHANNELS(CHANNELS), .LW(LW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .op_ctl    (f_ctl),
    .op_ox     (f_ox),
    .op_oy     (f_oy),
    .op_pair   (f_pair),
    .restart   (restart)
  );

  mbd_fifo #(.WIDTH(QW), .DEPTH(mbd_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_ctl, f_ox, f_oy, f_pair}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {q_ctl, q_ox, q_oy, q_pair} = q_rdata;

  mbd_back #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .CHANNELS(CHANNELS), .LW(LW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .q_empty    (q_empty),
    .q_ctl      (q_ctl),
    .q_ox       (q_ox),
    .q_oy       (q_oy),
    .q_pair     (q_pair),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hw/rtl/mbd_ram.sv */
module mbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mbd_fifo.sv */
`include "assert_macros.svh"

module mbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);

  `MBD_NEVER(a_fifo_no_overflow, push && full && !pop, "queue written while full")
  `MBD_NEVER(a_fifo_no_underflow, pop && empty, "queue read while empty")

endmodule

/* hw/rtl/mbd_front.sv */
module mbd_front #(
  parameter int MAX_SRC_WIDTH = 4096,
  parameter int CHANNELS      = 4,
  parameter int LW            = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mbd_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           q_full,
  output logic                           push,
  output mbd_pkg::op_ctl_t               op_ctl,
  output logic [LW-1:0]                  op_ox,
  output logic [mbd_pkg::COORD_W-1:0]    op_oy,
  output logic [CHANNELS*mbd_pkg::SUM_W-1:0] op_pair,
  output logic                           restart
);

  localparam int XW     = ($clog2(MAX_SRC_WIDTH) > LW) ? $clog2(MAX_SRC_WIDTH) : LW + 1;
  localparam int WW     = $clog2(MAX_SRC_WIDTH + 1);
  localparam int CW     = (WW > mbd_pkg::CFG_DATA_W) ? WW : mbd_pkg::CFG_DATA_W;
  localparam int HW     = mbd_pkg::CFG_DATA_W;
  localparam int PIX_W  = CHANNELS * mbd_pkg::CHAN_W;
  localparam int RST_W  = (mbd_pkg::RESET_SIZE > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH
                                                                : mbd_pkg::RESET_SIZE;
  localparam int RST_H  = mbd_pkg::RESET_SIZE;

  // sizes kept in the forms the counters compare against
  logic [XW-1:0]                 w_last_r, w_last_nxt;
  logic [WW-1:0]                 w_even_r, w_even_nxt;
  logic [LW-1:0]                 w2m1_r, w2m1_nxt;
  logic [mbd_pkg::ROW_W-1:0]     h_last_r, h_last_nxt;
  logic [mbd_pkg::ROW_W:0]       h_even_r, h_even_nxt;
  logic [mbd_pkg::COORD_W-1:0]   h2m1_r, h2m1_nxt;

  logic [XW-1:0]                 x_r, x_nxt;
  logic [mbd_pkg::ROW_W-1:0]     y_r, y_nxt;
  logic [PIX_W-1:0]              left_r, left_nxt;

  logic [CW-1:0]                 wval, wclamp;
  logic [HW-1:0]                 hval, hclamp;
  logic                          wr_width, wr_height;
  logic                          accept, kept, last_row;
  logic [PIX_W-1:0]              pix;

  assign wr_width  = cfg_we && (cfg_addr == mbd_pkg::REG_SRC_WIDTH);
  assign wr_height = cfg_we && (cfg_addr == mbd_pkg::REG_SRC_HEIGHT);
  assign restart   = wr_width || wr_height;

  always_comb begin
    wval   = CW'(cfg_wdata);
    wclamp = (wval < CW'(2)) ? CW'(2) :
             (wval > CW'(MAX_SRC_WIDTH)) ? CW'(MAX_SRC_WIDTH) : wval;
    hval   = cfg_wdata;
    hclamp = (hval < HW'(2)) ? HW'(2) :
             (hval > HW'(mbd_pkg::MAX_SRC_HEIGHT)) ? HW'(mbd_pkg::MAX_SRC_HEIGHT) : hval;
    w_last_nxt = XW'(wclamp - CW'(1));
    w_even_nxt = WW'({wclamp[CW-1:1], 1'b0});
    w2m1_nxt   = LW'(wclamp[CW-1:1] - (CW-1)'(1));
    h_last_nxt = mbd_pkg::ROW_W'(hclamp - HW'(1));
    h_even_nxt = (mbd_pkg::ROW_W+1)'({hclamp[HW-1:1], 1'b0});
    h2m1_nxt   = mbd_pkg::COORD_W'(hclamp[HW-1:1] - (HW-1)'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= XW'(RST_W - 1);
      w_even_r <= WW'((RST_W / 2) * 2);
      w2m1_r   <= LW'(RST_W / 2 - 1);
      h_last_r <= mbd_pkg::ROW_W'(RST_H - 1);
      h_even_r <= (mbd_pkg::ROW_W+1)'((RST_H / 2) * 2);
      h2m1_r   <= mbd_pkg::COORD_W'(RST_H / 2 - 1);
    end else begin
      if (wr_width) begin
        w_last_r <= w_last_nxt;
        w_even_r <= w_even_nxt;
        w2m1_r   <= w2m1_nxt;
      end
      if (wr_height) begin
        h_last_r <= h_last_nxt;
        h_even_r <= h_even_nxt;
        h2m1_r   <= h2m1_nxt;
      end
    end
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign pix       = in_tdata[PIX_W-1:0];

  // odd last column or row falls outside the kept area
  assign kept = (CW'(x_r) < CW'(w_even_r)) && ({1'b0, y_r} < h_even_r);

  assign op_ox = x_r[LW:1];
  assign op_oy = y_r[mbd_pkg::ROW_W-1:1];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_pair
    assign op_pair[c*mbd_pkg::SUM_W +: mbd_pkg::SUM_W] =
        mbd_pkg::SUM_W'(left_r[c*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W]) +
        mbd_pkg::SUM_W'(pix[c*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W]);
  end

  assign last_row = (op_oy == h2m1_r);

  always_comb begin
    op_ctl.emit      = y_r[0];
    op_ctl.copy      = last_row && (h2m1_r != '0);
    op_ctl.first_col = (op_ox == '0);
    op_ctl.last_col  = (op_ox == w2m1_r);
    op_ctl.first_row = (op_oy == '0);
    op_ctl.done      = (op_ox == w2m1_r) && last_row;
  end

  assign push = accept && kept && x_r[0];

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    left_nxt = left_r;
    if (restart) begin
      x_nxt    = '0;
      y_nxt    = '0;
      left_nxt = '0;
    end else if (accept) begin
      if (kept && !x_r[0]) begin
        left_nxt = pix;
      end
      if (x_r == w_last_r) begin
        x_nxt = '0;
        y_nxt = (y_r == h_last_r) ? '0 : y_r + mbd_pkg::ROW_W'(1);
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      left_r <= '0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

/* hw/rtl/mbd_back.sv */
`include "assert_macros.svh"

module mbd_back #(
  parameter int MAX_SRC_WIDTH = 4096,
  parameter int CHANNELS      = 4,
  parameter int LW            = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic                                q_empty,
  input  mbd_pkg::op_ctl_t                    q_ctl,
  input  logic [LW-1:0]                       q_ox,
  input  logic [mbd_pkg::COORD_W-1:0]         q_oy,
  input  logic [CHANNELS*mbd_pkg::SUM_W-1:0]  q_pair,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mbd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  localparam int LINE_DEPTH = MAX_SRC_WIDTH / 2;
  localparam int PIX_W      = CHANNELS * mbd_pkg::CHAN_W;
  localparam int PAIR_W     = CHANNELS * mbd_pkg::SUM_W;

  logic                        b_valid_r, b_valid_nxt;
  mbd_pkg::op_ctl_t            b_ctl_r;
  logic [LW-1:0]               b_ox_r;
  logic [mbd_pkg::COORD_W-1:0] b_oy_r;
  logic [PAIR_W-1:0]           b_pair_r;
  logic [PIX_W-1:0]            row_first_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [mbd_pkg::OUT_PIX_W-1:0] out_pix_r;
  logic [mbd_pkg::COORD_W-1:0] out_col_r, out_row_r;
  logic                        out_last_r;

  logic                        b_fire, b_adv, take_emit, fo_hazard;
  logic                        pl_we, pl_re, fo_re, fo_we;
  logic [PAIR_W-1:0]           pl_rdata;
  logic [PIX_W-1:0]            fo_rdata, avg, res;

  assign b_fire    = b_valid_r && (!out_valid_r || out_tready);
  assign b_adv     = !b_valid_r || b_fire;
  // a copy read waits while the first-row word of its column is being written
  assign fo_hazard = q_ctl.copy && fo_we && (q_ox == b_ox_r);
  // stores retire at once; an emit waits for room in the result stage
  assign q_pop     = !q_empty && (!q_ctl.emit || (b_adv && !fo_hazard));
  assign take_emit = q_pop && q_ctl.emit;
  assign pl_we     = q_pop && !q_ctl.emit;
  assign pl_re     = take_emit && !q_ctl.copy;
  assign fo_re     = take_emit && q_ctl.copy;

  mbd_ram #(.WIDTH(PAIR_W), .DEPTH(LINE_DEPTH)) u_pair_line (
    .clk   (clk),
    .we    (pl_we),
    .waddr (q_ox),
    .wdata (q_pair),
    .re    (pl_re),
    .raddr (q_ox),
    .rdata (pl_rdata)
  );

  mbd_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH)) u_first_row (
    .clk   (clk),
    .we    (fo_we),
    .waddr (b_ox_r),
    .wdata (res),
    .re    (fo_re),
    .raddr (q_ox),
    .rdata (fo_rdata)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_avg
    logic [mbd_pkg::SUM_W:0] tot;
    assign tot = (mbd_pkg::SUM_W+1)'(pl_rdata[c*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]) +
                 (mbd_pkg::SUM_W+1)'(b_pair_r[c*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]);
    assign avg[c*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W] = tot[mbd_pkg::CHAN_W+1:2];
  end

  // column seam: last column repeats the row's first pixel
  assign res = b_ctl_r.copy ? fo_rdata :
               (b_ctl_r.last_col && !b_ctl_r.first_col) ? row_first_r : avg;
  assign fo_we = b_fire && b_ctl_r.first_row && !b_ctl_r.copy;

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (take_emit) begin
      b_valid_nxt = 1'b1;
    end else if (b_fire) begin
      b_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (b_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      row_first_r <= '0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (restart) begin
        row_first_r <= '0;
      end else if (b_fire && !b_ctl_r.copy && b_ctl_r.first_col) begin
        row_first_r <= avg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_emit) begin
      b_ctl_r  <= q_ctl;
      b_ox_r   <= q_ox;
      b_oy_r   <= q_oy;
      b_pair_r <= q_pair;
    end
    if (b_fire) begin
      out_pix_r  <= mbd_pkg::OUT_PIX_W'(res);
      out_col_r  <= mbd_pkg::COORD_W'(b_ox_r);
      out_row_r  <= b_oy_r;
      out_last_r <= b_ctl_r.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_row_r, out_col_r, out_pix_r};

  `MBD_ASSERT(a_stage_holds, b_valid_r && out_valid_r && !out_tready |=> b_valid_r && $stable(b_ox_r), "result stage moved while output stalled")
  `MBD_ASSERT(a_out_from_stage, $rose(out_valid_r) |-> $past(b_valid_r), "result appeared without a pending emit")

endmodule

/* tb/tb_mip_box_downsample_seam.sv */
module tb_mip_box_downsample_seam;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SRC_W_MAX  = 4096;
  localparam int SRC_H_MAX  = mbd_pkg::MAX_SRC_HEIGHT;
  localparam int LINE_SLOTS = SRC_W_MAX / 2;
  localparam int SETTLE     = 12;
  localparam int RANDOM_PIXELS = 1100;

  // one output word with its tlast, laid out as {out_tlast, out_tdata}
  typedef struct packed {
    logic                          done;
    logic [1:0]                    fill;
    logic [mbd_pkg::COORD_W-1:0]   row;
    logic [mbd_pkg::COORD_W-1:0]   col;
    logic [mbd_pkg::OUT_PIX_W-1:0] pix;
  } out_word_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_addr;
  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [mbd_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [mbd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;

  mip_box_downsample_seam uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // predictor state
  int                            model_width;
  int                            model_height;
  logic [4*mbd_pkg::SUM_W-1:0]   line_pair_sums [LINE_SLOTS];
  logic [mbd_pkg::OUT_PIX_W-1:0] first_row_pixels [LINE_SLOTS];
  logic [mbd_pkg::OUT_PIX_W-1:0] held_left;
  logic [mbd_pkg::OUT_PIX_W-1:0] row_lead;
  int                            src_x;
  int                            src_y;

  out_word_t pending_out_pixels [$];
  int        mismatch_count;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("mip_box_downsample_seam: mismatch");
    $finish;
  end

  function automatic int clamp_extent(input int v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [mbd_pkg::IN_TDATA_W-1:0] rand_pixel();
    logic [mbd_pkg::IN_TDATA_W-1:0] p;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(0, 7))
        0:       p[8*c +: 8] = 8'h00;
        1:       p[8*c +: 8] = 8'hff;
        default: p[8*c +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  task automatic restart_position();
    held_left = '0;
    row_lead  = '0;
    src_x     = 0;
    src_y     = 0;
  endtask

  // one accepted source pixel: advance the position, queue the output pixel it completes
  task automatic box_average_step(input logic [mbd_pkg::IN_TDATA_W-1:0] pix);
    int w, h, w2, h2, ox, oy;
    logic [4*mbd_pkg::SUM_W-1:0]   pair;
    logic [4*mbd_pkg::SUM_W-1:0]   top;
    logic [mbd_pkg::SUM_W-1:0]     t;
    logic [mbd_pkg::OUT_PIX_W-1:0] avg;
    logic [mbd_pkg::OUT_PIX_W-1:0] res;
    out_word_t                     e;
    w  = clamp_extent(model_width, SRC_W_MAX);
    h  = clamp_extent(model_height, SRC_H_MAX);
    w2 = w / 2;
    h2 = h / 2;
    if (src_x < 2 * w2 && src_y < 2 * h2) begin
      ox = src_x / 2;
      oy = src_y / 2;
      if (src_x % 2 == 0) begin
        held_left = pix;
      end else begin
        for (int c = 0; c < 4; c++)
          pair[mbd_pkg::SUM_W*c +: mbd_pkg::SUM_W] =
              mbd_pkg::SUM_W'(held_left[8*c +: 8]) + mbd_pkg::SUM_W'(pix[8*c +: 8]);
        if (src_y % 2 == 0) begin
          line_pair_sums[ox] = pair;
        end else begin
          if (h2 > 1 && oy == h2 - 1) begin
            // last output row repeats the first one
            res = first_row_pixels[ox];
          end else begin
            top = line_pair_sums[ox];
            for (int c = 0; c < 4; c++) begin
              t = top[mbd_pkg::SUM_W*c +: mbd_pkg::SUM_W] +
                  pair[mbd_pkg::SUM_W*c +: mbd_pkg::SUM_W];
              avg[8*c +: 8] = t[mbd_pkg::SUM_W-1:2];
            end
            if (ox == 0) row_lead = avg;
            res = (ox == w2 - 1) ? row_lead : avg;
            if (oy == 0) first_row_pixels[ox] = res;
          end
          e.pix  = res;
          e.col  = mbd_pkg::COORD_W'(ox);
          e.row  = mbd_pkg::COORD_W'(oy);
          e.fill = '0;
          e.done = (ox == w2 - 1 && oy == h2 - 1);
          pending_out_pixels = {pending_out_pixels, e};
        end
      end
    end
    src_x++;
    if (src_x >= w) begin
      src_x = 0;
      src_y++;
      if (src_y >= h) src_y = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    $display("error at %0t: %s got %0d want %0d", $realtime, what, got_v, want_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : out_check
    out_word_t got;
    out_word_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = {out_tlast, out_tdata};
      if (pending_out_pixels.size() == 0) begin
        report_mismatch("word with none expected, col", got.col, 0);
      end else begin
        want = pending_out_pixels.pop_front();
        for (int c = 0; c < 4; c++)
          if (got.pix[8*c +: 8] !== want.pix[8*c +: 8])
            report_mismatch($sformatf("chan%0d_out", c), got.pix[8*c +: 8],
                            want.pix[8*c +: 8]);
        if (got.col !== want.col) report_mismatch("out_col", got.col, want.col);
        if (got.row !== want.row) report_mismatch("out_row", got.row, want.row);
        if (got.fill !== want.fill) report_mismatch("zero fill", got.fill, want.fill);
        if (got.done !== want.done) report_mismatch("level_done", got.done, want.done);
      end
    end
  end

  // receiver: segments of always ready, random ready and hard stalls
  initial begin : rx_pattern
    int mode;
    int span;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 24) : $urandom_range(1, 40);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= 1'b0;
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(input logic [mbd_pkg::IN_TDATA_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    box_average_step(pix);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_run(input int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // stop sending, wait for every expected word, then let the pipeline empty
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_out_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mbd_pkg::CFG_IDX_W-1:0] idx, input int val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= mbd_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mbd_pkg::REG_SRC_WIDTH) begin
      model_width = val & 16'h1fff;
      restart_position();
    end else if (idx == mbd_pkg::REG_SRC_HEIGHT) begin
      model_height = val & 16'h1fff;
      restart_position();
    end
  endtask

  // sizes from reset: 256 wide, one output row's worth
  task automatic test_reset_geometry();
    send_run(512);
  endtask

  // sizes below 2 clamp to a single 2x2 block; three levels back to back
  task automatic test_single_block();
    write_reg(mbd_pkg::REG_SRC_WIDTH, 0);
    write_reg(mbd_pkg::REG_SRC_HEIGHT, 1);
    repeat (4) send_pixel(32'hffff_ffff);
    send_pixel(32'h00ff_0103);
    send_pixel(32'h00ff_0000);
    send_pixel(32'h01ff_0000);
    send_pixel(32'h00fe_0002);
    repeat (4) send_pixel(32'h0000_0000);
  endtask

  // 2x2 output: column seam on row 0, row 1 copied from row 0
  task automatic test_seam_copy();
    write_reg(mbd_pkg::REG_SRC_WIDTH, 4);
    write_reg(mbd_pkg::REG_SRC_HEIGHT, 4);
    send_run(16);
  endtask

  task automatic test_random_levels();
    int sent, w, h, mode, style, npix, cut, ew;
    logic [mbd_pkg::CFG_IDX_W-1:0] spare_idx;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 19))
        0:       w = $urandom_range(0, 1);
        1:       w = $urandom_range(25, 128);
        default: w = $urandom_range(2, 24);
      endcase
      case ($urandom_range(0, 19))
        0:       h = $urandom_range(0, 1);
        1:       h = $urandom_range(13, 40);
        default: h = $urandom_range(2, 12);
      endcase
      if (w > 24 && h > 12) h = $urandom_range(2, 5);
      mode = (sent == 0) ? 0 : $urandom_range(0, 3);
      if (mode == 3) begin
        write_reg(mbd_pkg::REG_SRC_HEIGHT, h);
        write_reg(mbd_pkg::REG_SRC_WIDTH, w);
      end else begin
        if (mode != 2) write_reg(mbd_pkg::REG_SRC_WIDTH, w);
        if (mode != 1) write_reg(mbd_pkg::REG_SRC_HEIGHT, h);
      end
      ew   = clamp_extent(model_width, SRC_W_MAX);
      npix = ew * clamp_extent(model_height, SRC_H_MAX);
      if (npix > 3000) begin
        write_reg(mbd_pkg::REG_SRC_HEIGHT, 2);
        npix = ew * 2;
      end
      style = $urandom_range(0, 9);
      if (style <= 6) begin
        cut = npix * $urandom_range(1, 2);
        send_run(cut);
        sent += cut;
      end else if (style == 7) begin
        // level broken off partway, restarted by the next size write
        cut = $urandom_range(1, npix - 1);
        send_run(cut);
        sent += cut;
      end else if (style == 8) begin
        // pause inside the level; a write to an unused index must not restart it
        cut = $urandom_range(1, npix - 1);
        send_run(cut);
        spare_idx = mbd_pkg::REG_SRC_HEIGHT + mbd_pkg::CFG_IDX_W'(1) +
                    mbd_pkg::CFG_IDX_W'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) write_reg(spare_idx, $urandom_range(0, 8191));
        else drain();
        send_run(npix - cut);
        sent += npix;
      end else begin
        cut = $urandom_range(1, 3 * ew);
        send_run(cut);
        sent += cut;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    mismatch_count = 0;
    burst_left = 0;
    model_width  = mbd_pkg::RESET_SIZE;
    model_height = mbd_pkg::RESET_SIZE;
    for (int i = 0; i < LINE_SLOTS; i++) begin
      line_pair_sums[i]   = '0;
      first_row_pixels[i] = '0;
    end
    restart_position();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_geometry();
    test_single_block();
    test_seam_copy();
    test_random_levels();

    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0 && pending_out_pixels.size() == 0) begin
      $display("mip_box_downsample_seam: match");
    end else begin
      $display("mip_box_downsample_seam: mismatch");
    end
    $finish;
  end

endmodule
